>>> rtl/core/lcfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSTM cell core package
// Shared types, constants, rounding and clipping helpers and elaboration-time
// table functions of the scalar peephole LSTM cell core.
// ----------------------------------------------------------------------------
package lcfs_pkg;

	localparam int FANIN_MAX_DEF       = 64;
	localparam int ACT_TABLE_DEPTH_DEF = 256;

	localparam int SUM_W     = 22;
	localparam int FAN_IN_W  = 7;
	localparam int PARAM_W   = 48;
	localparam int CFG_IDX_W = 3;
	localparam int A_W       = 22;
	localparam int B_W       = 16;
	localparam int PROD_W    = A_W + B_W;
	localparam int ACC_W     = 40;
	localparam int Z_W       = ACC_W - 12;
	localparam int ACT_W     = 13;
	localparam int STEP_W    = 5;

	localparam logic [STEP_W-1:0] LAST_STEP  = 5'd18;
	localparam logic [ACC_W-1:0]  FORGET_ONE = 40'h0001000000;
	localparam logic [63:0]       Q24_ONE    = 64'h0000000001000000;

	typedef struct packed {
		logic signed [15:0] contribution;
		logic               start_of_series;
	} item_t;

	typedef struct packed {
		logic signed [15:0]  hidden_out;
		logic signed [15:0]  cell_out;
		logic [ACT_W-1:0]    out_gate;
		logic [ACT_W-1:0]    in_gate;
		logic [ACT_W-1:0]    keep_gate;
		logic                cell_saturated;
	} result_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OUT_GATE    = 3'd0,
		REG_IN_GATE     = 3'd1,
		REG_FORGET_GATE = 3'd2,
		REG_CANDIDATE   = 3'd3,
		REG_FAN_IN      = 3'd4
	} cfg_reg_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_CALC
	} state_t;

	typedef enum logic [2:0] {A_X, A_CPREV, A_F, A_I, A_O} a_sel_t;
	typedef enum logic [2:0] {B_WGT, B_U, B_CPREV, B_G, B_CELL} b_sel_t;
	typedef enum logic [1:0] {GS_O, GS_I, GS_F, GS_C} gate_sel_t;
	typedef enum logic [1:0] {ACC_HOLD, ACC_BIAS, ACC_CLEAR, ACC_ADD} acc_op_t;
	typedef enum logic [2:0] {
		CAP_NONE, CAP_O, CAP_I, CAP_F, CAP_G, CAP_CELL, CAP_HID
	} cap_t;

	typedef struct packed {
		a_sel_t    a_sel;
		b_sel_t    b_sel;
		gate_sel_t gate;
		acc_op_t   acc_op;
		logic      rom_tanh;
		cap_t      cap;
	} uop_t;

	localparam uop_t UOP_IDLE = '{
		a_sel: A_X, b_sel: B_WGT, gate: GS_O, acc_op: ACC_HOLD,
		rom_tanh: 1'b0, cap: CAP_NONE
	};

	// Round half up from Q.24 to Q.12.
	function automatic logic signed [Z_W-1:0] round_q12(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] t;
		t = v + ACC_W'(2048);
		return t[ACC_W-1:12];
	endfunction

	function automatic logic over16(input logic signed [Z_W-1:0] r);
		return (r > 32767) || (r < -32768);
	endfunction

	function automatic logic signed [15:0] clip16(input logic signed [Z_W-1:0] r);
		logic signed [15:0] c;
		if (r > 32767) begin
			c = 16'sh7fff;
		end else if (r < -32768) begin
			c = -16'sh8000;
		end else begin
			c = r[15:0];
		end
		return c;
	endfunction

	// e^(x/4096) in Q24 by a truncated Taylor series, evaluated at elaboration.
	function automatic logic [63:0] exp_q24(input logic [63:0] x);
		logic [63:0] Sum;
		logic [63:0] Term;
		logic [63:0] Div;
		logic        live;
		Sum  = Q24_ONE;
		Term = Q24_ONE;
		live = 1'b1;
		for (int N = 1; N <= 160; N++) begin
			if (live) begin
				Div  = 64'(4096 * N);
				Term = (Term * x) / Div;
				if (Term == 64'd0) begin
					live = 1'b0;
				end else begin
					Sum = Sum + Term;
				end
			end
		end
		return Sum;
	endfunction

	function automatic logic [ACT_W-1:0] sig_entry(input logic [63:0] a);
		logic [63:0] E;
		logic [63:0] Den;
		E   = exp_q24(a);
		Den = E + Q24_ONE;
		return ACT_W'((E * 64'd4096 + Den / 2) / Den);
	endfunction

	function automatic logic [ACT_W-1:0] tanh_entry(input logic [63:0] a);
		logic [63:0] E;
		logic [63:0] Den;
		E   = exp_q24(a * 64'd2);
		Den = E + Q24_ONE;
		return ACT_W'(((E - Q24_ONE) * 64'd4096 + Den / 2) / Den);
	endfunction

endpackage

>>> rtl/core/lstm_cell_forward_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scalar peephole LSTM cell core
// Sums incoming Q4.12 contributions and, once the fan-in count is reached,
// evaluates the three sigmoid gates, the tanh candidate, the new saturated
// cell value and the output on one shared multiplier.
//
//   Port group   Direction  Handshake            Beat
//   item         in         item_valid/stall     one contribution
//   result       out        result_valid/stall   one fired cell result
//   cfg          in         cfg_valid/ready      one register write
//
// An item that does not complete the fan-in is taken without a stall. A firing
// item keeps the block busy while the sequencer runs its micro-operations on
// the single 22 x 16 multiplier and the registered activation table read.
// Reset clears the gate parameters, the sum, the count and the cell value and
// sets the fan-in to one; the constant activation table needs no clearing pass.
// One finished result waits in the output register while new beats are
// taken; the sequencer waits at its last step while that result is stalled.
// ----------------------------------------------------------------------------
module lstm_cell_forward_step_core
	import lcfs_pkg::*;
#(
	parameter int FANIN_MAX       = FANIN_MAX_DEF,
	parameter int ACT_TABLE_DEPTH = ACT_TABLE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PARAM_W-1:0]   cfg_data
);

	localparam int CNT_W = $clog2(FANIN_MAX + 1);
	localparam int FAN_W = (CNT_W > FAN_IN_W) ? CNT_W : FAN_IN_W;

	logic [PARAM_W-1:0]        og_q;
	logic [PARAM_W-1:0]        ig_q;
	logic [PARAM_W-1:0]        fg_q;
	logic [31:0]               cand_q;
	logic [FAN_IN_W-1:0]       fan_in_q;

	logic signed [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]          count_q;
	logic signed [15:0]        cell_q;
	logic signed [SUM_W-1:0]   x_q;

	logic [ACT_W-1:0]          o_q;
	logic [ACT_W-1:0]          i_q;
	logic [ACT_W-1:0]          f_q;
	logic signed [ACT_W:0]     g_q;
	logic signed [15:0]        cell_new_q;
	logic                      sat_q;

	result_t                   result_q;
	logic                      result_valid_q;

	logic                      accept;
	logic                      fire;
	logic                      busy;
	logic                      hold;
	uop_t                      uop;
	logic signed [SUM_W:0]     sum_wide;
	logic signed [SUM_W-1:0]   sum_next;
	logic [FAN_W-1:0]          fan_ext;
	logic [FAN_W-1:0]          need;
	logic [FAN_W-1:0]          count_inc;

	logic [PARAM_W-1:0]        gate_params;
	logic signed [15:0]        w_sel;
	logic signed [15:0]        u_sel;
	logic signed [15:0]        b_sel16;
	logic signed [A_W-1:0]     mac_a;
	logic signed [B_W-1:0]     mac_b;
	logic signed [ACC_W-1:0]   bias;
	logic signed [ACC_W-1:0]   acc;
	logic signed [Z_W-1:0]     z;
	logic signed [ACT_W:0]     act;

	assign cfg_ready    = 1'b1;
	assign item_stall   = busy;
	assign accept       = item_valid && !item_stall;
	assign hold         = result_valid_q && result_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		sum_wide = (SUM_W + 1)'(sum_q) + (SUM_W + 1)'(item.contribution);
		if (sum_wide > (SUM_W + 1)'(2097151)) begin
			sum_next = SUM_W'(2097151);
		end else if (sum_wide < -(SUM_W + 1)'(2097152)) begin
			sum_next = -SUM_W'(2097152);
		end else begin
			sum_next = sum_wide[SUM_W-1:0];
		end
		fan_ext = FAN_W'(fan_in_q);
		if (fan_ext == '0) begin
			need = FAN_W'(1);
		end else if (fan_ext > FAN_W'(FANIN_MAX)) begin
			need = FAN_W'(FANIN_MAX);
		end else begin
			need = fan_ext;
		end
		count_inc = FAN_W'(count_q) + FAN_W'(1);
		fire      = (count_inc >= need);
	end

	always_comb begin
		case (uop.gate)
			GS_O:    gate_params = og_q;
			GS_I:    gate_params = ig_q;
			GS_F:    gate_params = fg_q;
			default: gate_params = {16'h0000, cand_q};
		endcase
		w_sel   = gate_params[15:0];
		u_sel   = (uop.gate == GS_C) ? 16'sh0000 : gate_params[31:16];
		b_sel16 = (uop.gate == GS_C) ? gate_params[31:16] : gate_params[47:32];
		bias    = {{(ACC_W - 28){b_sel16[15]}}, b_sel16, 12'h000};
		if (uop.gate == GS_F) begin
			bias = bias + FORGET_ONE;
		end
	end

	always_comb begin
		case (uop.a_sel)
			A_X:     mac_a = x_q;
			A_CPREV: mac_a = A_W'(cell_q);
			A_F:     mac_a = A_W'(f_q);
			A_I:     mac_a = A_W'(i_q);
			A_O:     mac_a = A_W'(o_q);
			default: mac_a = x_q;
		endcase
		case (uop.b_sel)
			B_WGT:   mac_b = w_sel;
			B_U:     mac_b = u_sel;
			B_CPREV: mac_b = cell_q;
			B_G:     mac_b = B_W'(g_q);
			B_CELL:  mac_b = cell_new_q;
			default: mac_b = w_sel;
		endcase
	end

	assign z = round_q12(acc);

	lcfs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && fire),
		.hold   (hold),
		.busy   (busy),
		.uop    (uop)
	);

	lcfs_mac u_mac (
		.clk    (clk),
		.acc_op (uop.acc_op),
		.a      (mac_a),
		.b      (mac_b),
		.bias   (bias),
		.acc    (acc)
	);

	lcfs_act_rom #(
		.ACT_TABLE_DEPTH (ACT_TABLE_DEPTH)
	) u_act_rom (
		.clk      (clk),
		.z        (z),
		.tanh_sel (uop.rom_tanh),
		.act      (act)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			og_q     <= '0;
			ig_q     <= '0;
			fg_q     <= '0;
			cand_q   <= '0;
			fan_in_q <= FAN_IN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OUT_GATE:    og_q     <= cfg_data;
				REG_IN_GATE:     ig_q     <= cfg_data;
				REG_FORGET_GATE: fg_q     <= cfg_data;
				REG_CANDIDATE:   cand_q   <= cfg_data[31:0];
				REG_FAN_IN:      fan_in_q <= cfg_data[FAN_IN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q          <= '0;
			count_q        <= '0;
			cell_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				sum_q   <= fire ? '0 : sum_next;
				count_q <= fire ? '0 : CNT_W'(count_inc);
				if (item.start_of_series) begin
					cell_q <= '0;
				end
			end
			if (uop.cap == CAP_CELL) begin
				cell_q <= clip16(z);
			end
			if (uop.cap == CAP_HID) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= sum_next;
		end
		case (uop.cap)
			CAP_O: o_q <= act[ACT_W-1:0];
			CAP_I: i_q <= act[ACT_W-1:0];
			CAP_F: f_q <= act[ACT_W-1:0];
			CAP_G: g_q <= act;
			CAP_CELL: begin
				cell_new_q <= clip16(z);
				sat_q      <= over16(z);
			end
			CAP_HID: begin
				result_q.hidden_out     <= clip16(z);
				result_q.cell_out       <= cell_new_q;
				result_q.out_gate       <= o_q;
				result_q.in_gate        <= i_q;
				result_q.keep_gate      <= f_q;
				result_q.cell_saturated <= sat_q;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/core/lcfs_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSTM cell shared multiply-accumulate unit
// One signed 22 x 16 multiplier with a registered product, feeding an
// accumulator that can be loaded with a bias, cleared or added to.
// ----------------------------------------------------------------------------
module lcfs_mac
	import lcfs_pkg::*;
(
	input  logic                    clk,
	input  acc_op_t                 acc_op,
	input  logic signed [A_W-1:0]   a,
	input  logic signed [B_W-1:0]   b,
	input  logic signed [ACC_W-1:0] bias,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		case (acc_op)
			ACC_BIAS:  acc_q <= bias;
			ACC_CLEAR: acc_q <= '0;
			ACC_ADD:   acc_q <= acc_q + ACC_W'(prod_s1);
			default:   acc_q <= acc_q;
		endcase
	end

	assign acc = acc_q;

endmodule

>>> rtl/core/lcfs_act_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSTM cell activation table
// Sigmoid and tanh table with a registered read, indexed by the magnitude
// of a Q4.12 argument, with the sign applied after the read (-t or 1 - s).
// ----------------------------------------------------------------------------
module lcfs_act_rom
	import lcfs_pkg::*;
#(
	parameter int ACT_TABLE_DEPTH = ACT_TABLE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic signed [Z_W-1:0] z,
	input  logic                  tanh_sel,
	output logic signed [ACT_W:0] act
);

	localparam int K_W     = $clog2(ACT_TABLE_DEPTH);
	localparam int ADDR_W  = $clog2(2 * ACT_TABLE_DEPTH);
	localparam int SCALE_W = 15 + $clog2(ACT_TABLE_DEPTH + 1);

	typedef logic [ACT_W-1:0] rom_t [2 * ACT_TABLE_DEPTH];

	function automatic rom_t build_rom();
		rom_t        t;
		logic [63:0] Arg;
		for (int k = 0; k < ACT_TABLE_DEPTH; k++) begin
			Arg                    = 64'((k * 32768) / ACT_TABLE_DEPTH);
			t[k]                   = sig_entry(Arg);
			t[ACT_TABLE_DEPTH + k] = tanh_entry(Arg);
		end
		return t;
	endfunction

	localparam rom_t ROM = build_rom();

	logic [Z_W-1:0]     mag;
	logic [14:0]        mag_clip;
	logic [SCALE_W-1:0] scaled;
	logic [K_W-1:0]     k_idx;
	logic [ADDR_W-1:0]  addr;
	logic [ACT_W-1:0]   rom_q;
	logic               neg_q;
	logic               tanh_q;

	always_comb begin
		mag      = z[Z_W-1] ? Z_W'(-z) : Z_W'(z);
		mag_clip = (mag > Z_W'(32767)) ? 15'h7fff : mag[14:0];
		scaled   = SCALE_W'(mag_clip) * SCALE_W'(ACT_TABLE_DEPTH);
		k_idx    = scaled[15 +: K_W];
		addr     = tanh_sel ? ADDR_W'(ACT_TABLE_DEPTH) + ADDR_W'(k_idx) : ADDR_W'(k_idx);
	end

	always_ff @(posedge clk) begin
		rom_q  <= ROM[addr];
		neg_q  <= z[Z_W-1];
		tanh_q <= tanh_sel;
	end

	always_comb begin
		if (!neg_q) begin
			act = (ACT_W + 1)'(rom_q);
		end else if (tanh_q) begin
			act = -(ACT_W + 1)'(rom_q);
		end else begin
			act = (ACT_W + 1)'(4096) - (ACT_W + 1)'(rom_q);
		end
	end

endmodule

>>> rtl/core/lcfs_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSTM cell sequencer
// Steps through the fixed micro-operation list that drives the shared
// multiply-accumulate unit and the activation table for one firing.
// ----------------------------------------------------------------------------
module lcfs_seq
	import lcfs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic hold,
	output logic busy,
	output uop_t uop
);

	state_t            state_q;
	state_t            state_next;
	logic [STEP_W-1:0] step_q;
	logic              at_last;

	function automatic uop_t step_uop(input logic [STEP_W-1:0] step);
		uop_t u;
		u = UOP_IDLE;
		case (step)
			5'd0: begin
				u.gate = GS_O; u.a_sel = A_X; u.b_sel = B_WGT; u.acc_op = ACC_BIAS;
			end
			5'd1: begin
				u.gate = GS_O; u.a_sel = A_CPREV; u.b_sel = B_U; u.acc_op = ACC_ADD;
			end
			5'd2: begin
				u.acc_op = ACC_ADD;
			end
			5'd3: begin
				u.gate = GS_I; u.a_sel = A_X; u.b_sel = B_WGT; u.acc_op = ACC_BIAS;
			end
			5'd4: begin
				u.cap = CAP_O;
				u.gate = GS_I; u.a_sel = A_CPREV; u.b_sel = B_U; u.acc_op = ACC_ADD;
			end
			5'd5: begin
				u.acc_op = ACC_ADD;
			end
			5'd6: begin
				u.gate = GS_F; u.a_sel = A_X; u.b_sel = B_WGT; u.acc_op = ACC_BIAS;
			end
			5'd7: begin
				u.cap = CAP_I;
				u.gate = GS_F; u.a_sel = A_CPREV; u.b_sel = B_U; u.acc_op = ACC_ADD;
			end
			5'd8: begin
				u.acc_op = ACC_ADD;
			end
			5'd9: begin
				u.gate = GS_C; u.a_sel = A_X; u.b_sel = B_WGT; u.acc_op = ACC_BIAS;
			end
			5'd10: begin
				u.cap = CAP_F; u.acc_op = ACC_ADD;
			end
			5'd11: begin
				u.rom_tanh = 1'b1;
				u.a_sel = A_F; u.b_sel = B_CPREV; u.acc_op = ACC_CLEAR;
			end
			5'd12: begin
				u.cap = CAP_G; u.acc_op = ACC_ADD;
			end
			5'd13: begin
				u.a_sel = A_I; u.b_sel = B_G;
			end
			5'd14: begin
				u.acc_op = ACC_ADD;
			end
			5'd15: begin
				u.cap = CAP_CELL; u.acc_op = ACC_CLEAR;
			end
			5'd16: begin
				u.a_sel = A_O; u.b_sel = B_CELL;
			end
			5'd17: begin
				u.acc_op = ACC_ADD;
			end
			5'd18: begin
				u.cap = CAP_HID;
			end
			default: begin
				u = UOP_IDLE;
			end
		endcase
		return u;
	endfunction

	assign at_last = (step_q == LAST_STEP);

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_next = ST_CALC;
				end
			end
			ST_CALC: begin
				if (at_last && !hold) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy = 1'b0;
		uop  = UOP_IDLE;
		case (state_q)
			ST_CALC: begin
				busy = 1'b1;
				uop  = step_uop(step_q);
				if (at_last && hold) begin
					uop.cap = CAP_NONE;
				end
			end
			default: begin
				busy = 1'b0;
				uop  = UOP_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_CALC && !at_last) begin
				step_q <= step_q + STEP_W'(1);
			end else if (state_next == ST_IDLE) begin
				step_q <= '0;
			end
		end
	end

endmodule
